>>> src/keypad_time_set_entry_core_defines.svh
// ----------------------------------------------------------------------------
// Keypad time set entry: assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_TIME_SET_ENTRY_CORE_DEFINES_SVH
`define KEYPAD_TIME_SET_ENTRY_CORE_DEFINES_SVH

// same-cycle implication
`define KTSE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ktse assertion failed");

// next-cycle implication
`define KTSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ktse assertion failed");

`endif

>>> src/ktse_pkg.sv
// ----------------------------------------------------------------------------
// Keypad time set entry: package
// Key codes, digit positions, transaction and state types, digit helpers.
// ----------------------------------------------------------------------------
package ktse_pkg;

  localparam logic [7:0] KEY_ENTER  = 8'h23;
  localparam logic [7:0] KEY_ACCEPT = 8'h11;
  localparam logic [7:0] KEY_BACK   = 8'h12;
  localparam logic [7:0] KEY_CANCEL = 8'h13;
  localparam logic [7:0] KEY_ZERO   = 8'd48;

  localparam logic [7:0] DIGIT_MAX  = 8'd9;
  localparam logic [3:0] HT_MAX     = 4'd2;
  localparam logic [3:0] TENS_MAX   = 4'd5;
  localparam logic [5:0] HOUR_MAX   = 6'd23;
  localparam logic [5:0] MS_MAX     = 6'd59;

  // digit positions within hh:mm:ss
  localparam logic [2:0] POS_HT = 3'd0;
  localparam logic [2:0] POS_HO = 3'd1;
  localparam logic [2:0] POS_MT = 3'd2;
  localparam logic [2:0] POS_MO = 3'd3;
  localparam logic [2:0] POS_ST = 3'd4;
  localparam logic [2:0] POS_SO = 3'd5;

  // cursor columns that hold the ':' separators
  localparam logic [2:0] COL_SEP_HM = 3'd2;
  localparam logic [2:0] COL_SEP_MS = 3'd5;

  typedef enum logic [1:0] {
    ST_DISPLAY = 2'b01,
    ST_SET     = 2'b10
  } mode_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic [4:0] now_hours;
    logic [5:0] now_minutes;
    logic [5:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic       set_mode;
    logic [2:0] digit_position;
    logic [2:0] cursor_column;
    logic       cursor_on;
    logic [4:0] edit_hours;
    logic [5:0] edit_minutes;
    logic [5:0] edit_seconds;
    logic       commit_time;
    logic       digit_rejected;
  } out_item_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] pos;
    logic [2:0] col;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } edit_state_t;

  localparam edit_state_t STATE_RESET = '{
    mode:    ST_SET,
    pos:     POS_HT,
    col:     3'd0,
    hours:   5'd0,
    minutes: 6'd0,
    seconds: 6'd0
  };

  // tens digit of a 6-bit value (0..63)
  function automatic logic [2:0] tens6(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60) begin
      t = 3'd6;
    end else if (v >= 6'd50) begin
      t = 3'd5;
    end else if (v >= 6'd40) begin
      t = 3'd4;
    end else if (v >= 6'd30) begin
      t = 3'd3;
    end else if (v >= 6'd20) begin
      t = 3'd2;
    end else if (v >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    return t;
  endfunction

  // tens digit times ten
  function automatic logic [5:0] tens_base(input logic [2:0] t);
    return 6'(t) * 6'd10;
  endfunction

endpackage

>>> src/keypad_time_set_entry_core.sv
// ----------------------------------------------------------------------------
// Keypad time set entry core
// Keypad-driven hh:mm:ss setting controller, one key per transaction.
// ----------------------------------------------------------------------------
// A user sends one key code per input transaction along with the running
// clock's time; each one yields exactly one result transaction carrying the
// mode, digit position, cursor column and blink, the time being edited, and
// the commit and reject flags. '#' in display mode loads the running time
// (clamped to 23:59:59) and starts editing at hour tens; digit keys are
// range-checked per position, back steps one digit left, accept commits and
// cancel abandons. After reset the block is already in set mode at 00:00:00.
// Throughput is one transaction per clock while in_stall is low; a result
// appears once its key has passed the input register, then the result
// register. The edit state is updated in the same cycle a key moves into the
// result register, so the only serial dependence is that state register
// loop. in_stall rises only when both stages are full and out_stall is high.
// ----------------------------------------------------------------------------
`include "keypad_time_set_entry_core_defines.svh"

module keypad_time_set_entry_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ktse_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ktse_pkg::out_item_t  out_item
);
  import ktse_pkg::*;

  // input stage
  logic        s1_valid_r;
  in_item_t    s1_item_r;

  // result stage
  logic        out_valid_r;
  out_item_t   out_item_r;

  // edit state
  edit_state_t st_r;
  edit_state_t st_nxt;
  out_item_t   res;

  logic        adv;    // input stage moves into the result register
  logic        in_acc;

  // result register is free when empty or being drained this cycle
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  ktse_step u_step (
    .cur  (st_r),
    .item (s1_item_r),
    .nxt  (st_nxt),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // state and reported mode agree after each update
  `KTSE_ASSERT_NEXT(a_mode_tracks, adv, (st_r.mode == ST_SET) == out_item_r.set_mode)
  // a commit always leaves set mode
  `KTSE_ASSERT_IMPL(a_commit_exits, out_valid_r && out_item_r.commit_time, !out_item_r.set_mode)
  // a rejected digit happens only in set mode and stops the blink
  `KTSE_ASSERT_IMPL(a_reject_form, out_valid_r && out_item_r.digit_rejected, out_item_r.set_mode && !out_item_r.cursor_on)
  // position never runs past second ones
  `KTSE_ASSERT_IMPL(a_pos_range, 1'b1, st_r.pos <= POS_SO)
  // cursor never lands on a separator column
  `KTSE_ASSERT_IMPL(a_col_no_sep, 1'b1, st_r.col != COL_SEP_HM && st_r.col != COL_SEP_MS)

endmodule

>>> src/ktse_step.sv
// ----------------------------------------------------------------------------
// Keypad time set entry: key step
// Next edit state and result transaction for one key.
// ----------------------------------------------------------------------------
module ktse_step (
  input  ktse_pkg::edit_state_t cur,
  input  ktse_pkg::in_item_t    item,
  output ktse_pkg::edit_state_t nxt,
  output ktse_pkg::out_item_t   res
);
  import ktse_pkg::*;

  logic [7:0] dgt;
  logic [3:0] d4;
  logic       is_digit;

  logic [2:0] h_tens, m_tens, s_tens;
  logic [5:0] h_rem, m_rem, s_rem;
  logic [5:0] h_cand;
  logic [2:0] back_pos;

  logic cursor_on, commit, rejected;

  assign dgt      = item.key_code - KEY_ZERO;
  assign d4       = dgt[3:0];
  assign is_digit = (dgt <= DIGIT_MAX);

  assign h_tens = tens6({1'b0, cur.hours});
  assign m_tens = tens6(cur.minutes);
  assign s_tens = tens6(cur.seconds);
  assign h_rem  = {1'b0, cur.hours} - tens_base(h_tens);
  assign m_rem  = cur.minutes - tens_base(m_tens);
  assign s_rem  = cur.seconds - tens_base(s_tens);
  assign h_cand = tens_base(h_tens) + 6'(d4);

  assign back_pos = cur.pos - 3'd1;

  always_comb begin
    nxt       = cur;
    cursor_on = 1'b0;
    commit    = 1'b0;
    rejected  = 1'b0;
    case (cur.mode)
      ST_DISPLAY: begin
        if (item.key_code == KEY_ENTER) begin
          nxt.mode    = ST_SET;
          nxt.hours   = ({1'b0, item.now_hours} > HOUR_MAX) ? HOUR_MAX[4:0]
                                                            : item.now_hours;
          nxt.minutes = (item.now_minutes > MS_MAX) ? MS_MAX : item.now_minutes;
          nxt.seconds = (item.now_seconds > MS_MAX) ? MS_MAX : item.now_seconds;
          nxt.pos     = POS_HT;
          nxt.col     = 3'd0;
          cursor_on   = 1'b1;
        end
      end
      ST_SET: begin
        if (is_digit) begin
          cursor_on = 1'b1;
          case (cur.pos)
            POS_HT: begin
              if (d4 > HT_MAX) begin
                rejected  = 1'b1;
                cursor_on = 1'b0;
              end else begin
                nxt.hours = h_rem[4:0] + 5'(d4) * 5'd10;
                nxt.pos   = POS_HO;
                nxt.col   = cur.col + 3'd1;
              end
            end
            POS_HO: begin
              if (h_cand > HOUR_MAX) begin
                rejected  = 1'b1;
                cursor_on = 1'b0;
              end else begin
                nxt.hours = h_cand[4:0];
                nxt.pos   = POS_MT;
                nxt.col   = cur.col + 3'd2;
              end
            end
            POS_MT: begin
              if (d4 > TENS_MAX) begin
                rejected  = 1'b1;
                cursor_on = 1'b0;
              end else begin
                nxt.minutes = m_rem + 6'(d4) * 6'd10;
                nxt.pos     = POS_MO;
                nxt.col     = cur.col + 3'd1;
              end
            end
            POS_MO: begin
              nxt.minutes = tens_base(m_tens) + 6'(d4);
              nxt.pos     = POS_ST;
              nxt.col     = cur.col + 3'd2;
            end
            POS_ST: begin
              if (d4 > TENS_MAX) begin
                rejected  = 1'b1;
                cursor_on = 1'b0;
              end else begin
                nxt.seconds = s_rem + 6'(d4) * 6'd10;
                nxt.pos     = POS_SO;
                nxt.col     = cur.col + 3'd1;
              end
            end
            POS_SO: begin
              // last digit: position and cursor stay put
              nxt.seconds = tens_base(s_tens) + 6'(d4);
            end
            default: begin
              // unreachable position codes accept the digit, change nothing
            end
          endcase
        end else if (item.key_code == KEY_BACK && cur.pos != POS_HT) begin
          nxt.pos   = back_pos;
          nxt.col   = back_pos[0] ? (cur.col - 3'd2) : (cur.col - 3'd1);
          cursor_on = 1'b1;
        end else if (item.key_code == KEY_ACCEPT || item.key_code == KEY_CANCEL) begin
          nxt.mode = ST_DISPLAY;
          commit   = (item.key_code == KEY_ACCEPT);
        end else begin
          cursor_on = 1'b1;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  always_comb begin
    res.set_mode       = (nxt.mode == ST_SET);
    res.digit_position = nxt.pos;
    res.cursor_column  = nxt.col;
    res.cursor_on      = cursor_on;
    res.edit_hours     = nxt.hours;
    res.edit_minutes   = nxt.minutes;
    res.edit_seconds   = nxt.seconds;
    res.commit_time    = commit;
    res.digit_rejected = rejected;
  end

endmodule
